>>> rtl/bhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types and constants for the binary heap priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

    // Heap geometry
    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = 7;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    // Command modes
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Error codes
    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_POP_EMPTY = 2'd1;
    localparam logic [1:0] ERR_PUSH_FULL = 2'd2;

    typedef logic [KEY_WIDTH-1:0] key_t;
    typedef logic [ADDR_W-1:0]    addr_t;

    // Input transaction
    typedef struct packed {
        logic                        mode;
        logic signed [KEY_WIDTH-1:0] key_value;
    } cmd_t;

    // Result transaction
    typedef struct packed {
        logic signed [31:0] top_key;
        logic [6:0]         entry_count;
        logic               is_empty;
        logic [1:0]         error_code;
    } result_t;

    // Request from the sequencer to the heap store
    typedef struct packed {
        logic  we;
        addr_t waddr;
        key_t  wdata;
        addr_t ra;
        addr_t rb;
    } mem_req_t;

endpackage

>>> rtl/bhpq_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_store
// Heap key memory: one write port, two read ports with registered data.
// ----------------------------------------------------------------------------
module bhpq_store
    import bhpq_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output key_t     rd_a,
    output key_t     rd_b
);

    key_t mem [CAPACITY];
    key_t rd_a_reg;
    key_t rd_b_reg;

    // Write and registered reads
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_a_reg <= mem[req.ra];
        rd_b_reg <= mem[req.rb];
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

>>> rtl/bhpq_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_cmp
// Shared key comparator: true when lhs belongs strictly above rhs.
// ----------------------------------------------------------------------------
module bhpq_cmp
    import bhpq_pkg::*;
(
    input  key_t lhs,
    input  key_t rhs,
    input  logic order_max,
    output logic better
);

    // Signed compare, direction set by the heap order
    always_comb
    begin
        if (order_max)
        begin
            better = ($signed(lhs) > $signed(rhs));
        end
        else
        begin
            better = ($signed(lhs) < $signed(rhs));
        end
    end

endmodule

>>> rtl/bhpq_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_seq
// Heap sequencer: runs sift-up and sift-down one level at a time over the
// store and the shared comparator, and issues one result per command.
// ----------------------------------------------------------------------------
module bhpq_seq
    import bhpq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  cmd_t     cmd,
    input  logic     order_max,
    output logic     busy,
    output logic     result_valid,
    output result_t  result
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_UP      = 3'd1;
    localparam logic [2:0] ST_UP_FIN  = 3'd2;
    localparam logic [2:0] ST_DN_LAST = 3'd3;
    localparam logic [2:0] ST_DN_STEP = 3'd4;
    localparam logic [2:0] ST_DN_PICK = 3'd5;
    localparam logic [2:0] ST_DN_CMP  = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       err_reg, err_next;
    logic             done_reg, done_next;
    addr_t            pos_reg, pos_next;
    addr_t            pick_pos_reg, pick_pos_next;
    key_t             key_reg, key_next;
    key_t             pick_key_reg, pick_key_next;
    key_t             root_reg, root_next;

    mem_req_t         mem_req;
    key_t             rd_a;
    key_t             rd_b;
    key_t             cmp_a;
    key_t             cmp_b;
    logic             cmp_better;

    logic [CNT_W-1:0]  last_idx;
    addr_t             up_idx;
    logic [ADDR_W+1:0] left_idx;
    logic [ADDR_W+1:0] right_idx;
    logic [ADDR_W+1:0] cnt_ext;

    function automatic addr_t parent_of(input addr_t p);
        addr_t q;
        q = p - 1'b1;
        return q >> 1;
    endfunction

    bhpq_store u_store (
        .clk  (clk),
        .req  (mem_req),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    bhpq_cmp u_cmp (
        .lhs       (cmp_a),
        .rhs       (cmp_b),
        .order_max (order_max),
        .better    (cmp_better)
    );

    // Index arithmetic
    assign last_idx  = cnt_reg - 1'b1;
    assign up_idx    = parent_of(pos_reg);
    assign left_idx  = {1'b0, pos_reg, 1'b1};
    assign right_idx = left_idx + 1'b1;
    assign cnt_ext   = (ADDR_W + 2)'(cnt_reg);

    // Sequencer next-state logic
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        err_next      = err_reg;
        done_next     = 1'b0;
        pos_next      = pos_reg;
        pick_pos_next = pick_pos_reg;
        key_next      = key_reg;
        pick_key_next = pick_key_reg;
        mem_req       = '0;
        cmp_a         = key_reg;
        cmp_b         = rd_a;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    err_next = ERR_OK;
                    if (cmd.mode == MODE_PUSH)
                    begin
                        if (cnt_reg == CNT_FULL)
                        begin
                            err_next  = ERR_PUSH_FULL;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            key_next = cmd.key_value;
                            pos_next = cnt_reg[ADDR_W-1:0];
                            cnt_next = cnt_reg + 1'b1;
                            if (cnt_reg == '0)
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = '0;
                                mem_req.wdata = cmd.key_value;
                                done_next     = 1'b1;
                            end
                            else
                            begin
                                mem_req.ra = parent_of(cnt_reg[ADDR_W-1:0]);
                                state_next = ST_UP;
                            end
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            err_next  = ERR_POP_EMPTY;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            cnt_next = last_idx;
                            if (last_idx == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                mem_req.ra = last_idx[ADDR_W-1:0];
                                state_next = ST_DN_LAST;
                            end
                        end
                    end
                end
            end

            // One sift-up level: compare with parent, move parent down if the key beats it, else place the key
            ST_UP:
            begin
                cmp_a = key_reg;
                cmp_b = rd_a;
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg;
                if (cmp_better)
                begin
                    mem_req.wdata = rd_a;
                    pos_next      = up_idx;
                    if (up_idx == '0)
                    begin
                        state_next = ST_UP_FIN;
                    end
                    else
                    begin
                        mem_req.ra = parent_of(up_idx);
                    end
                end
                else
                begin
                    mem_req.wdata = key_reg;
                    done_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            // Key reached the root
            ST_UP_FIN:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg;
                mem_req.wdata = key_reg;
                done_next     = 1'b1;
                state_next    = ST_IDLE;
            end

            // Last entry read back, hole now at the root
            ST_DN_LAST:
            begin
                key_next   = rd_a;
                pos_next   = '0;
                state_next = ST_DN_STEP;
            end

            // Fetch both children, or settle if the hole is a leaf
            ST_DN_STEP:
            begin
                if (left_idx >= cnt_ext)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = pos_reg;
                    mem_req.wdata = key_reg;
                    done_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    mem_req.ra = left_idx[ADDR_W-1:0];
                    mem_req.rb = right_idx[ADDR_W-1:0];
                    state_next = ST_DN_PICK;
                end
            end

            // Choose the preferred child, left on a tie
            ST_DN_PICK:
            begin
                cmp_a = rd_b;
                cmp_b = rd_a;
                if ((right_idx < cnt_ext) && cmp_better)
                begin
                    pick_pos_next = right_idx[ADDR_W-1:0];
                    pick_key_next = rd_b;
                end
                else
                begin
                    pick_pos_next = left_idx[ADDR_W-1:0];
                    pick_key_next = rd_a;
                end
                state_next = ST_DN_CMP;
            end

            // Move the child up if it beats the sifting key
            ST_DN_CMP:
            begin
                cmp_a = pick_key_reg;
                cmp_b = key_reg;
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg;
                if (cmp_better)
                begin
                    mem_req.wdata = pick_key_reg;
                    pos_next      = pick_pos_reg;
                    state_next    = ST_DN_STEP;
                end
                else
                begin
                    mem_req.wdata = key_reg;
                    done_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Shadow copy of the root entry
    always_comb
    begin
        root_next = root_reg;
        if (mem_req.we && (mem_req.waddr == '0))
        begin
            root_next = mem_req.wdata;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            err_reg   <= ERR_OK;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        pick_pos_reg <= pick_pos_next;
        key_reg      <= key_next;
        pick_key_reg <= pick_key_next;
        root_reg     <= root_next;
    end

    // Outputs
    assign busy                = (state_reg != ST_IDLE);
    assign result_valid        = done_reg;
    assign result.top_key      = (cnt_reg == '0) ? '0 : root_reg;
    assign result.entry_count  = cnt_reg;
    assign result.is_empty     = (cnt_reg == '0);
    assign result.error_code   = err_reg;

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("heap count above capacity");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe while a sift is running");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (err_reg == ERR_POP_EMPTY)) |-> (cnt_reg == '0))
        else $error("pop-empty error with entries held");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) && start && (cmd.mode == MODE_PUSH)
            && (cnt_reg != CNT_FULL))
        |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("push did not advance the count");

endmodule

>>> rtl/binary_heap_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Array-based binary heap of signed keys with selectable min or max order.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction (cmd: push a key or pop the top) is taken at a
//   clock edge with start high and busy low. busy stays high while the heap
//   is repaired, one level at a time, through a single comparator and a
//   two-read, one-write key memory.
//   Push: busy during sift-up, a level at a time. Pop: busy while the last
//   entry is read back and sifted down, each level fetching both children,
//   picking one and comparing it. Errors, a push into an empty queue and a
//   pop of the last entry keep busy low. Errors leave the heap untouched.
//   Each command gives one result transaction: result_valid pulses for one
//   cycle, the cycle after the repair ends, and result holds top, count,
//   empty flag and error code. The receiver cannot stall; busy is already
//   low during that pulse, so the next command may be issued then.
//   cfg_data selects the order (0 smallest on top, 1 largest); write it via
//   cfg_valid/cfg_ready only while the queue is idle.
//   Reset empties the queue and selects min order; memory contents are not
//   cleared, the values of entries beyond the count are never used.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue
    import bhpq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  logic    cfg_data,
    output logic    result_valid,
    output result_t result
);

    logic order_reg;

    // Order select register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            order_reg <= cfg_data;
        end
    end

    assign cfg_ready = !busy;

    bhpq_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .order_max    (order_reg),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
